// ----- rtl/crcp_pkg.sv -----
// Shared types, constants and functions of the CRC-checked relay command parser.
`default_nettype none

package crcp_pkg;

   localparam int MAX_FRAME   = 64;
   localparam int NUM_RELAYS  = 8;
   localparam int CNT_W       = $clog2(MAX_FRAME + 1);

   // The queue depth must be a power of two so that the pointers wrap on their own.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_TERM = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CRC_SEP   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOKEN_SEP = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_INVERT    = 2'd3;

   localparam logic [7:0]  RESET_LINE_TERM = 8'd10;
   localparam logic [7:0]  RESET_CRC_SEP   = 8'd47;
   localparam logic [7:0]  RESET_TOKEN_SEP = 8'd44;
   localparam logic [7:0]  CHAR_R          = 8'h52;
   localparam logic [7:0]  CHAR_ZERO       = 8'h30;
   localparam logic [7:0]  CHAR_NINE       = 8'h39;
   localparam logic [7:0]  CHAR_PLUS       = 8'h2B;
   localparam logic [7:0]  CHAR_MINUS      = 8'h2D;
   localparam logic [7:0]  CHAR_SPACE      = 8'h20;
   localparam logic [7:0]  CHAR_TAB        = 8'h09;
   localparam logic [7:0]  CHAR_CR         = 8'h0D;
   localparam logic [31:0] CRC_POLY        = 32'hEDB88320;

   localparam logic [NUM_RELAYS-1:0] RELAY_ALL = '1;

   typedef enum logic [1:0] {
      BK_OTHER,
      BK_TERM,
      BK_CSEP,
      BK_TSEP
   } byte_kind_type;

   typedef enum logic [1:0] {
      ROLE_CMD,
      ROLE_ID,
      ROLE_VALUE
   } role_type;

   typedef enum logic [1:0] {
      SHAPE_EMPTY,
      SHAPE_R,
      SHAPE_OTHER
   } shape_type;

   typedef enum logic [1:0] {
      ST_NONE,
      ST_ACCEPTED,
      ST_CRC_BAD,
      ST_MALFORMED
   } status_type;

   typedef struct packed {
      logic stopped;
      logic started;
      logic neg;
   } num_flags_type;

   typedef struct packed {
      logic [7:0]    data;
      byte_kind_type kind;
      logic          cut;
   } item_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_ADDR_W-1:0] addr;
      logic [7:0]            wdata;
   } csr_write_type;

   // One byte of the reflected CRC-32.
   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] relay_levels_f(input logic [NUM_RELAYS-1:0] rs,
                                                 input logic inv);
      logic [15:0] w;
      w = 16'(rs ^ (inv ? RELAY_ALL : '0));
      return w[7:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/crcp_front.sv -----
// Front end: separator registers, byte classification and frame length cut.
`default_nettype none

module crcp_front
   import crcp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire csr_write_type csr,
   input  wire logic          req_tvalid,
   input  wire logic [7:0]    req_tdata,
   output logic               req_tready,
   input  wire logic          queue_full,
   output logic               push,
   output item_type           push_item
);

   logic [7:0]       line_term_ff, crc_sep_ff, token_sep_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_term_ff <= RESET_LINE_TERM;
         crc_sep_ff   <= RESET_CRC_SEP;
         token_sep_ff <= RESET_TOKEN_SEP;
      end else if (csr.we) begin
         case (csr.addr)
            CSR_LINE_TERM: line_term_ff <= csr.wdata;
            CSR_CRC_SEP:   crc_sep_ff   <= csr.wdata;
            CSR_TOKEN_SEP: token_sep_ff <= csr.wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      req_tready     = !queue_full;
      push           = req_tvalid && !queue_full;
      push_item.data = req_tdata;
      push_item.cut  = 1'b0;
      count_in       = count_ff;

      // The terminator wins over the crc separator, which wins over the token separator.
      if (req_tdata == line_term_ff) begin
         push_item.kind = BK_TERM;
      end else if (req_tdata == crc_sep_ff) begin
         push_item.kind = BK_CSEP;
      end else if (req_tdata == token_sep_ff) begin
         push_item.kind = BK_TSEP;
      end else begin
         push_item.kind = BK_OTHER;
      end

      if (push_item.kind == BK_TERM) begin
         count_in = '0;
      end else if (count_ff == CNT_W'(MAX_FRAME - 1)) begin
         push_item.cut = 1'b1;
         count_in      = '0;
      end else begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (push) begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/crcp_queue.sv -----
// Short queue of classified bytes between the front end and the back end.
`default_nettype none

module crcp_queue
   import crcp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output item_type      pop_item,
   output logic          not_empty
);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] fill_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   assign full      = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- rtl/crcp_back.sv -----
// Back end: CRC, CRC text, token parsing, staged relay updates and the result register.
`default_nettype none

module crcp_back
   import crcp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire csr_write_type csr,
   input  wire logic          item_valid,
   input  wire item_type      item,
   output logic               pop,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast,
   output logic [1:0]         rsp_tuser
);

   logic [31:0]           crc_ff, crc_in;
   logic [31:0]           rcrc_ff, rcrc_in;
   logic                  ovf_ff, ovf_in;
   logic                  in_crc_ff, in_crc_in;
   logic                  stopped_ff, stopped_in;
   role_type              role_ff, role_in;
   shape_type             shape_ff, shape_in;
   logic [7:0]            nval_ff, nval_in;
   num_flags_type         flags_ff, flags_in;
   logic [3:0]            pid_ff, pid_in;
   logic                  pid_ok_ff, pid_ok_in;
   logic [NUM_RELAYS-1:0] mask_ff, mask_in;
   logic [NUM_RELAYS-1:0] vals_ff, vals_in;
   logic [NUM_RELAYS-1:0] relay_ff, relay_in;
   logic [NUM_RELAYS-1:0] id_bit;
   logic                  invert_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic       is_digit, is_space, tok_end, tok_byte, frame_end, id_neg;
   logic [3:0] dval;
   logic [35:0] rcrc_wide;
   logic [11:0] nval_wide;
   status_type  status;

   always_comb begin
      pop        = item_valid && (!rsp_valid_ff || rsp_tready);
      is_digit   = item.data inside {[CHAR_ZERO:CHAR_NINE]};
      is_space   = item.data inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
      dval       = 4'(item.data - CHAR_ZERO);
      rcrc_wide  = ({4'd0, rcrc_ff} << 3) + ({4'd0, rcrc_ff} << 1) + 36'(dval);
      nval_wide  = ({4'd0, nval_ff} << 3) + ({4'd0, nval_ff} << 1) + 12'(dval);
      id_neg     = flags_ff.neg && (nval_ff != '0);
      for (int i = 0; i < NUM_RELAYS; i++) begin
         id_bit[i] = (pid_ff == 4'(i));
      end

      crc_in     = crc_ff;
      rcrc_in    = rcrc_ff;
      ovf_in     = ovf_ff;
      in_crc_in  = in_crc_ff;
      stopped_in = stopped_ff;
      role_in    = role_ff;
      shape_in   = shape_ff;
      nval_in    = nval_ff;
      flags_in   = flags_ff;
      pid_in     = pid_ff;
      pid_ok_in  = pid_ok_ff;
      mask_in    = mask_ff;
      vals_in    = vals_ff;
      relay_in   = relay_ff;
      tok_end    = 1'b0;
      tok_byte   = 1'b0;
      frame_end  = 1'b0;
      status     = ST_NONE;

      if (item.kind == BK_TERM) begin
         frame_end = 1'b1;
      end else begin
         if (!in_crc_ff) begin
            if (item.kind == BK_CSEP) begin
               tok_end   = 1'b1;
               in_crc_in = 1'b1;
            end else begin
               crc_in = crc_step(crc_ff, item.data);
               if (item.kind == BK_TSEP) begin
                  tok_end = 1'b1;
               end else begin
                  tok_byte = 1'b1;
               end
            end
         end else if (!stopped_ff) begin
            // CRC digits run until the first non-digit or until the value leaves 32 bits.
            if (is_digit) begin
               if (rcrc_wide[35:32] != '0) begin
                  ovf_in     = 1'b1;
                  stopped_in = 1'b1;
               end else begin
                  rcrc_in = rcrc_wide[31:0];
               end
            end else begin
               stopped_in = 1'b1;
            end
         end
         frame_end = item.cut;
      end

      if (tok_byte) begin
         if (role_ff == ROLE_CMD) begin
            shape_in = (shape_ff == SHAPE_EMPTY && item.data == CHAR_R) ? SHAPE_R : SHAPE_OTHER;
         end else if (!flags_ff.stopped) begin
            if (is_digit) begin
               nval_in          = (nval_wide > 12'd255) ? 8'hFF : nval_wide[7:0];
               flags_in.started = 1'b1;
            end else if (!flags_ff.started && is_space) begin
               flags_in = flags_ff;
            end else if (!flags_ff.started &&
                         (item.data == CHAR_PLUS || item.data == CHAR_MINUS)) begin
               flags_in.started = 1'b1;
               flags_in.neg     = (item.data == CHAR_MINUS);
            end else begin
               flags_in.stopped = 1'b1;
            end
         end
      end

      if (tok_end) begin
         case (role_ff)
            ROLE_CMD: begin
               if (shape_ff == SHAPE_R) begin
                  role_in = ROLE_ID;
               end
            end
            ROLE_ID: begin
               pid_ok_in = !id_neg && (nval_ff < 8'(NUM_RELAYS));
               pid_in    = nval_ff[3:0];
               role_in   = ROLE_VALUE;
            end
            ROLE_VALUE: begin
               if (pid_ok_ff) begin
                  mask_in = mask_ff | id_bit;
                  vals_in = (nval_ff != '0) ? (vals_ff | id_bit) : (vals_ff & ~id_bit);
               end
               role_in = ROLE_CMD;
            end
            default: role_in = ROLE_CMD;
         endcase
         shape_in = SHAPE_EMPTY;
         nval_in  = '0;
         flags_in = '0;
      end

      if (frame_end) begin
         if (!in_crc_in) begin
            status = ST_MALFORMED;
         end else if (!ovf_in && rcrc_in == ~crc_in) begin
            relay_in = (relay_ff & ~mask_in) | (vals_in & mask_in);
            status   = ST_ACCEPTED;
         end else begin
            status = ST_CRC_BAD;
         end
         crc_in     = '1;
         rcrc_in    = '0;
         ovf_in     = 1'b0;
         in_crc_in  = 1'b0;
         stopped_in = 1'b0;
         role_in    = ROLE_CMD;
         shape_in   = SHAPE_EMPTY;
         nval_in    = '0;
         flags_in   = '0;
         pid_in     = '0;
         pid_ok_in  = 1'b0;
         mask_in    = '0;
         vals_in    = '0;
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (pop) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = relay_levels_f(relay_in, invert_ff);
         rsp_last_in   = frame_end;
         rsp_status_in = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= '1;
         rcrc_ff    <= '0;
         ovf_ff     <= 1'b0;
         in_crc_ff  <= 1'b0;
         stopped_ff <= 1'b0;
         role_ff    <= ROLE_CMD;
         shape_ff   <= SHAPE_EMPTY;
         nval_ff    <= '0;
         flags_ff   <= '0;
         pid_ff     <= '0;
         pid_ok_ff  <= 1'b0;
         mask_ff    <= '0;
         vals_ff    <= '0;
         relay_ff   <= '0;
      end else if (pop) begin
         crc_ff     <= crc_in;
         rcrc_ff    <= rcrc_in;
         ovf_ff     <= ovf_in;
         in_crc_ff  <= in_crc_in;
         stopped_ff <= stopped_in;
         role_ff    <= role_in;
         shape_ff   <= shape_in;
         nval_ff    <= nval_in;
         flags_ff   <= flags_in;
         pid_ff     <= pid_in;
         pid_ok_ff  <= pid_ok_in;
         mask_ff    <= mask_in;
         vals_ff    <= vals_in;
         relay_ff   <= relay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b1;
      end else if (csr.we && csr.addr == CSR_INVERT) begin
         invert_ff <= csr.wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// ----- rtl/crc_checked_relay_command_parser_unit.sv -----
// Top level of the CRC-checked relay command parser.
// Usage:
// Bytes of a serial command line enter on the req_ channel, one byte per beat. Every
// byte gives exactly one result beat on the rsp_ channel, in order. rsp_tdata carries
// the relay pin levels after polarity; rsp_tlast is high when the byte ended a frame
// (terminator or length cut); rsp_tuser carries the frame status: none, accepted,
// CRC mismatch or overflow, malformed.
// The csr_ port writes the terminator, the two separators and the output polarity;
// write it only while no beat is in flight.
// An accepted byte is first written into the queue; the back end pops it and loads
// its result into the result register on the rsp_ port. Throughput: one byte per
// clock while rsp_tready is high; the back end steps CRC and tokens per popped byte.
// Reset clears the frame state, turns all relays off and restores the register
// defaults; no clearing pass is needed, so req_tready is high right after reset.
// When rsp_tready is low the result holds, the two-entry queue fills, and then
// req_tready drops until the receiver takes a beat.
`default_nettype none

module crc_checked_relay_command_parser_unit
   import crcp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] rx_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] relay_levels
   output logic                       rsp_tlast,   // frame_done
   output logic [1:0]                 rsp_tuser,   // [1:0] frame_status
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [7:0]            csr_wdata
);

   csr_write_type csr;
   item_type      push_item, pop_item;
   logic          push, pop, queue_full, queue_valid;

   assign csr.we    = csr_we;
   assign csr.addr  = csr_addr;
   assign csr.wdata = csr_wdata;

   crcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tready (req_tready),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   crcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .not_empty (queue_valid)
   );

   crcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .item_valid (queue_valid),
      .item       (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- rtl/crcp_checker.sv -----
// Port-level checker of the relay command parser and its bind to the top level.
`default_nettype none

module crcp_checker
   import crcp_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic [1:0] rsp_tuser
);

   // The result register is empty after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // A stalled result beat holds its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // A frame end always carries a status, and only a frame end does.
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != ST_NONE)))
      else $error("frame status does not match frame end");

   // The input side only backs up while a result beat is waiting.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

endmodule

bind crc_checked_relay_command_parser_unit crcp_checker u_checker (.*);

`default_nettype wire
